FILE: rtl/rvda_pkg.sv
// shared types, opcodes and select codes for the rv32i subset decoder and alu
package rvda_pkg;

    localparam logic [6:0] OPC_RTYPE  = 7'b0110011;
    localparam logic [6:0] OPC_ITYPE  = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    localparam logic [1:0] CLS_ADD   = 2'd0;
    localparam logic [1:0] CLS_SUB   = 2'd1;
    localparam logic [1:0] CLS_RTYPE = 2'd2;
    localparam logic [1:0] CLS_ITYPE = 2'd3;

    localparam logic [2:0] SEL_ADD = 3'd0;
    localparam logic [2:0] SEL_SUB = 3'd1;
    localparam logic [2:0] SEL_AND = 3'd2;
    localparam logic [2:0] SEL_OR  = 3'd3;
    localparam logic [2:0] SEL_XOR = 3'd4;
    localparam logic [2:0] SEL_SRA = 3'd5;

    localparam logic [2:0] F3_ADD = 3'b000;
    localparam logic [2:0] F3_XOR = 3'b100;
    localparam logic [2:0] F3_SR  = 3'b101;
    localparam logic [2:0] F3_OR  = 3'b110;
    localparam logic [2:0] F3_AND = 3'b111;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] first_operand;
        logic [31:0] second_operand;
    } item_t;

    typedef struct packed {
        logic        reg_write;
        logic        use_immediate;
        logic        is_branch;
        logic        mem_read;
        logic        mem_write;
        logic        mem_to_reg;
        logic [1:0]  alu_op_class;
        logic [2:0]  alu_select;
        logic [31:0] immediate_value;
        logic [31:0] alu_result;
        logic        zero_flag;
    } result_t;

    // decoder to alu
    typedef struct packed {
        logic        known;
        logic        use_immediate;
        logic [2:0]  alu_select;
    } alu_ctrl_t;

endpackage

FILE: rtl/rvda_decode.sv
// main control, immediate generation and alu select
module rvda_decode
    import rvda_pkg::*;
(
    input  logic [31:0] instruction,
    output logic        reg_write,
    output logic        mem_read,
    output logic        mem_write,
    output logic        mem_to_reg,
    output logic        is_branch,
    output logic [1:0]  alu_op_class,
    output logic [31:0] immediate_value,
    output alu_ctrl_t   alu_ctrl
);

    logic [6:0] opcode;
    logic [2:0] funct3;
    logic       bit30;
    logic       sign;
    logic       known;
    logic       use_imm;
    logic [2:0] alu_sel;

    assign opcode = instruction[6:0];
    assign funct3 = instruction[14:12];
    assign bit30  = instruction[30];
    assign sign   = instruction[31];

    assign alu_ctrl.known         = known;
    assign alu_ctrl.use_immediate = use_imm;
    assign alu_ctrl.alu_select    = alu_sel;

    always_comb
    begin
        reg_write    = 1'b0;
        mem_read     = 1'b0;
        mem_write    = 1'b0;
        mem_to_reg   = 1'b0;
        is_branch    = 1'b0;
        alu_op_class = CLS_ADD;
        known        = 1'b1;
        use_imm      = 1'b0;
        case (opcode)
            OPC_RTYPE:
            begin
                reg_write    = 1'b1;
                alu_op_class = CLS_RTYPE;
            end
            OPC_ITYPE:
            begin
                reg_write    = 1'b1;
                use_imm      = 1'b1;
                alu_op_class = CLS_ITYPE;
            end
            OPC_LOAD:
            begin
                reg_write  = 1'b1;
                use_imm    = 1'b1;
                mem_read   = 1'b1;
                mem_to_reg = 1'b1;
            end
            OPC_STORE:
            begin
                use_imm   = 1'b1;
                mem_write = 1'b1;
            end
            OPC_BRANCH:
            begin
                is_branch    = 1'b1;
                alu_op_class = CLS_SUB;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (opcode)
            OPC_ITYPE, OPC_LOAD:
                immediate_value = {{20{sign}}, instruction[31:20]};
            OPC_STORE:
                immediate_value = {{20{sign}}, instruction[31:25], instruction[11:7]};
            OPC_BRANCH:
                immediate_value = {{20{sign}}, instruction[7], instruction[30:25],
                                   instruction[11:8], 1'b0};
            OPC_LUI, OPC_AUIPC:
                immediate_value = {instruction[31:12], 12'd0};
            OPC_JAL:
                immediate_value = {{12{sign}}, instruction[19:12], instruction[20],
                                   instruction[30:21], 1'b0};
            default:
                immediate_value = 32'd0;
        endcase
    end

    // andi and the logical shifts fall through to add
    always_comb
    begin
        alu_sel = SEL_ADD;
        if (known)
        begin
            case (alu_op_class)
                CLS_ADD:
                    alu_sel = SEL_ADD;
                CLS_SUB:
                    alu_sel = SEL_SUB;
                CLS_RTYPE:
                begin
                    case (funct3)
                        F3_ADD:  alu_sel = bit30 ? SEL_SUB : SEL_ADD;
                        F3_AND:  alu_sel = SEL_AND;
                        F3_OR:   alu_sel = SEL_OR;
                        F3_XOR:  alu_sel = SEL_XOR;
                        F3_SR:   alu_sel = bit30 ? SEL_SRA : SEL_ADD;
                        default: alu_sel = SEL_ADD;
                    endcase
                end
                default:
                begin
                    case (funct3)
                        F3_XOR:  alu_sel = SEL_XOR;
                        F3_OR:   alu_sel = SEL_OR;
                        F3_SR:   alu_sel = bit30 ? SEL_SRA : SEL_ADD;
                        default: alu_sel = SEL_ADD;
                    endcase
                end
            endcase
        end
    end

endmodule

FILE: rtl/rvda_alu.sv
// alu: operand select, add/sub/logic/sra and zero flag
module rvda_alu
    import rvda_pkg::*;
(
    input  alu_ctrl_t   alu_ctrl,
    input  logic [31:0] first_operand,
    input  logic [31:0] second_operand,
    input  logic [31:0] immediate_value,
    output logic [31:0] alu_result,
    output logic        zero_flag
);

    logic [31:0] op_b;

    assign op_b = alu_ctrl.use_immediate ? immediate_value : second_operand;

    always_comb
    begin
        case (alu_ctrl.alu_select)
            SEL_ADD: alu_result = first_operand + op_b;
            SEL_SUB: alu_result = first_operand - op_b;
            SEL_AND: alu_result = first_operand & op_b;
            SEL_OR:  alu_result = first_operand | op_b;
            SEL_XOR: alu_result = first_operand ^ op_b;
            SEL_SRA: alu_result = $unsigned($signed(first_operand) >>> op_b[4:0]);
            default: alu_result = 32'd0;
        endcase
        // unknown, lui, auipc and jal give no alu output at all
        if (!alu_ctrl.known)
        begin
            alu_result = 32'd0;
        end
    end

    assign zero_flag = alu_ctrl.known && (alu_result == 32'd0);

endmodule

FILE: rtl/rv32i_subset_decode_alu_top.sv
// top level: input register, decode and alu, result register
// Takes one instruction word with its two source register values per transfer and
// returns the control signals, immediate, alu select, alu result and zero flag for it.
// An instruction is accepted every clock cycle unless item_stall is high; each result is
// loaded into the result register from the input register after one pass through the
// decoder and alu. The sustained rate is one instruction per cycle, held back only by
// stall on the result side, which reaches item_stall once both the input and result
// registers are full. Opcodes outside r-type, i-type alu, lw, sw, beq, lui, auipc and
// jal give an all-zero result; lui, auipc and jal give only the immediate.
module rv32i_subset_decode_alu_top
    import rvda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    item_t       s1_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    result_t     out_next;
    logic        item_accept;
    logic        s1_advance;
    alu_ctrl_t   alu_ctrl;
    logic [31:0] imm_value;

    // result slot is free when empty or being taken this cycle
    assign s1_advance  = !out_valid_reg || !result_stall;
    assign item_stall  = s1_valid_reg && !s1_advance;
    assign item_accept = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (item_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = s1_advance ? s1_valid_reg : out_valid_reg;
    end

    rvda_decode u_decode (
        .instruction     (s1_item_reg.instruction),
        .reg_write       (out_next.reg_write),
        .mem_read        (out_next.mem_read),
        .mem_write       (out_next.mem_write),
        .mem_to_reg      (out_next.mem_to_reg),
        .is_branch       (out_next.is_branch),
        .alu_op_class    (out_next.alu_op_class),
        .immediate_value (imm_value),
        .alu_ctrl        (alu_ctrl)
    );

    assign out_next.use_immediate   = alu_ctrl.use_immediate;
    assign out_next.alu_select      = alu_ctrl.alu_select;
    assign out_next.immediate_value = imm_value;

    rvda_alu u_alu (
        .alu_ctrl        (alu_ctrl),
        .first_operand   (s1_item_reg.first_operand),
        .second_operand  (s1_item_reg.second_operand),
        .immediate_value (imm_value),
        .alu_result      (out_next.alu_result),
        .zero_flag       (out_next.zero_flag)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_advance && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_zero_matches: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.zero_flag == ((result.mem_write || result.is_branch
            || result.reg_write) && (result.alu_result == 32'd0))))
        else $error("zero flag does not match alu result");

    a_select_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.alu_select != 3'd6 && result.alu_select != 3'd7))
        else $error("alu select out of range");

    a_load_writeback: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.mem_to_reg |-> result.mem_read && result.reg_write)
        else $error("mem_to_reg without load");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with free space");

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("held instruction dropped");

endmodule

FILE: tb/rv32i_subset_decode_alu_top_tb.sv
// testbench for the rv32i subset decoder and alu: queued driver, predictor and checking monitor
`timescale 1ns / 100ps

module rv32i_subset_decode_alu_top_tb;
    import rvda_pkg::*;

    localparam logic [6:0] F7_BASE     = 7'b0000000;
    localparam logic [6:0] F7_ALT      = 7'b0100000;
    localparam logic [2:0] F3_SLL      = 3'b001;
    localparam logic [2:0] F3_SLT      = 3'b010;
    localparam logic [2:0] F3_SLTU     = 3'b011;
    localparam logic [2:0] F3_WORD     = 3'b010;
    localparam logic [2:0] F3_BEQ      = 3'b000;
    localparam logic [6:0] OPC_ALL_ONE = 7'b1111111;
    localparam logic [6:0] OPC_ALL_ZERO = 7'b0000000;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int PHASE_ITEMS    = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    item_t   pending_items[$];
    result_t expected_results[$];
    logic    input_taken = 1'b0;
    int      accepted_items = 0;
    int      total_items = 0;
    int      errors = 0;
    int      quiet_cycles = 0;
    int      send_idle_pct;
    int      stall_pct;

    rv32i_subset_decode_alu_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic result_t decode_execute(item_t it);
        result_t     r;
        logic [31:0] ins;
        logic [6:0]  opc;
        logic [2:0]  f3;
        logic        alt;
        logic        known;
        logic [31:0] b_in;
        r     = '0;
        ins   = it.instruction;
        opc   = ins[6:0];
        f3    = ins[14:12];
        alt   = ins[30];
        known = 1'b1;
        case (opc)
            OPC_RTYPE:
            begin
                r.reg_write    = 1'b1;
                r.alu_op_class = CLS_RTYPE;
            end
            OPC_ITYPE:
            begin
                r.reg_write     = 1'b1;
                r.use_immediate = 1'b1;
                r.alu_op_class  = CLS_ITYPE;
            end
            OPC_LOAD:
            begin
                r.reg_write     = 1'b1;
                r.use_immediate = 1'b1;
                r.mem_read      = 1'b1;
                r.mem_to_reg    = 1'b1;
                r.alu_op_class  = CLS_ADD;
            end
            OPC_STORE:
            begin
                r.use_immediate = 1'b1;
                r.mem_write     = 1'b1;
                r.alu_op_class  = CLS_ADD;
            end
            OPC_BRANCH:
            begin
                r.is_branch    = 1'b1;
                r.alu_op_class = CLS_SUB;
            end
            default: known = 1'b0;
        endcase

        case (opc)
            OPC_ITYPE, OPC_LOAD:
                r.immediate_value = {{20{ins[31]}}, ins[31:20]};
            OPC_STORE:
                r.immediate_value = {{20{ins[31]}}, ins[31:25], ins[11:7]};
            OPC_BRANCH:
                r.immediate_value = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
            OPC_LUI, OPC_AUIPC:
                r.immediate_value = {ins[31:12], 12'b0};
            OPC_JAL:
                r.immediate_value = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
            default:
                r.immediate_value = '0;
        endcase

        // lui, auipc, jal and unknown opcodes leave the alu fields at zero
        if (known)
        begin
            case (r.alu_op_class)
                CLS_ADD: r.alu_select = SEL_ADD;
                CLS_SUB: r.alu_select = SEL_SUB;
                CLS_RTYPE:
                begin
                    case (f3)
                        F3_ADD:  r.alu_select = alt ? SEL_SUB : SEL_ADD;
                        F3_AND:  r.alu_select = SEL_AND;
                        F3_OR:   r.alu_select = SEL_OR;
                        F3_XOR:  r.alu_select = SEL_XOR;
                        F3_SR:   r.alu_select = alt ? SEL_SRA : SEL_ADD;
                        default: r.alu_select = SEL_ADD;
                    endcase
                end
                default:
                begin
                    // andi and srli fall back to add
                    case (f3)
                        F3_XOR:  r.alu_select = SEL_XOR;
                        F3_OR:   r.alu_select = SEL_OR;
                        F3_SR:   r.alu_select = alt ? SEL_SRA : SEL_ADD;
                        default: r.alu_select = SEL_ADD;
                    endcase
                end
            endcase

            b_in = r.use_immediate ? r.immediate_value : it.second_operand;
            case (r.alu_select)
                SEL_ADD: r.alu_result = it.first_operand + b_in;
                SEL_SUB: r.alu_result = it.first_operand - b_in;
                SEL_AND: r.alu_result = it.first_operand & b_in;
                SEL_OR:  r.alu_result = it.first_operand | b_in;
                SEL_XOR: r.alu_result = it.first_operand ^ b_in;
                SEL_SRA: r.alu_result = $unsigned($signed(it.first_operand) >>> b_in[4:0]);
                default: r.alu_result = '0;
            endcase
            r.zero_flag = (r.alu_result == 32'd0);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    // upper holds instruction bits 31:20, the rs1 and rd fields are random
    task automatic push_directed(input logic [11:0] upper, input logic [2:0] f3,
                                 input logic [6:0] opc, input logic [31:0] a,
                                 input logic [31:0] b);
        item_t      it;
        logic [4:0] rs1;
        logic [4:0] rd;
        rs1 = 5'($urandom);
        rd  = 5'($urandom);
        it.instruction    = {upper, rs1, f3, rd, opc};
        it.first_operand  = a;
        it.second_operand = b;
        pending_items.push_back(it);
    endtask

    // phase settings follow the number of accepted transfers
    always_comb
    begin
        case ((accepted_items / PHASE_ITEMS) % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 67; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 67; end
            default: begin send_idle_pct = 33; stall_pct = 33; end
        endcase
    end

    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || input_taken))
        begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item       <= pending_items.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        result_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin : monitor
        result_t oldest;
        if (rst_n)
        begin
            input_taken <= item_valid && !item_stall;
            if (item_valid && !item_stall)
            begin
                expected_results.push_back(decode_execute(item));
                accepted_items++;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, got %h", $time, result);
                    errors++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    compare_field("reg_write", 32'(oldest.reg_write), 32'(result.reg_write));
                    compare_field("use_immediate", 32'(oldest.use_immediate),
                                  32'(result.use_immediate));
                    compare_field("is_branch", 32'(oldest.is_branch), 32'(result.is_branch));
                    compare_field("mem_read", 32'(oldest.mem_read), 32'(result.mem_read));
                    compare_field("mem_write", 32'(oldest.mem_write), 32'(result.mem_write));
                    compare_field("mem_to_reg", 32'(oldest.mem_to_reg),
                                  32'(result.mem_to_reg));
                    compare_field("alu_op_class", 32'(oldest.alu_op_class),
                                  32'(result.alu_op_class));
                    compare_field("alu_select", 32'(oldest.alu_select),
                                  32'(result.alu_select));
                    compare_field("immediate_value", oldest.immediate_value,
                                  result.immediate_value);
                    compare_field("alu_result", oldest.alu_result, result.alu_result);
                    compare_field("zero_flag", 32'(oldest.zero_flag), 32'(result.zero_flag));
                end
            end
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        item_t      it;
        int         pick;
        logic [6:0] opc;

        // directed: every select, extremes, shift of zero, fallbacks to add, u/j and unknown
        push_directed({F7_BASE, 5'd2}, F3_ADD, OPC_RTYPE, 32'h7fffffff, 32'h00000001);
        push_directed({F7_BASE, 5'd2}, F3_ADD, OPC_RTYPE, 32'hffffffff, 32'h00000001);
        push_directed({F7_ALT, 5'd3}, F3_ADD, OPC_RTYPE, 32'hdeadbeef, 32'hdeadbeef);
        push_directed({F7_BASE, 5'd4}, F3_AND, OPC_RTYPE, 32'hffffffff, 32'h00000000);
        push_directed({F7_BASE, 5'd5}, F3_OR, OPC_RTYPE, 32'h00000000, 32'h00000000);
        push_directed({F7_BASE, 5'd6}, F3_XOR, OPC_RTYPE, 32'hffffffff, 32'hffffffff);
        push_directed({F7_ALT, 5'd7}, F3_SR, OPC_RTYPE, 32'h80000000, 32'h0000001f);
        push_directed({F7_ALT, 5'd8}, F3_SR, OPC_RTYPE, 32'h80000001, 32'hffffffe0);
        push_directed({F7_BASE, 5'd9}, F3_SR, OPC_RTYPE, 32'h80000000, 32'h00000004);
        push_directed({F7_BASE, 5'd1}, F3_SLL, OPC_RTYPE, 32'h12345678, 32'h00000003);
        push_directed({F7_ALT, 5'd1}, F3_SLTU, OPC_RTYPE, 32'h00000005, 32'hffffffff);
        push_directed(12'h800, F3_ADD, OPC_ITYPE, 32'h00000800, 32'hffffffff);
        push_directed(12'hfff, F3_XOR, OPC_ITYPE, 32'h0f0f0f0f, 32'h00000000);
        push_directed(12'h7ff, F3_OR, OPC_ITYPE, 32'h80000000, 32'h00000000);
        push_directed(12'h0f0, F3_AND, OPC_ITYPE, 32'hffffffff, 32'h00000000);
        push_directed({F7_ALT, 5'd4}, F3_SR, OPC_ITYPE, 32'h80000000, 32'h00000000);
        push_directed({F7_BASE, 5'd4}, F3_SR, OPC_ITYPE, 32'h80000000, 32'h00000000);
        push_directed(12'hfff, F3_WORD, OPC_LOAD, 32'h00000001, 32'h00000000);
        push_directed(12'h800, F3_WORD, OPC_STORE, 32'h7fffffff, 32'hffffffff);
        push_directed(12'h000, F3_BEQ, OPC_BRANCH, 32'hffffffff, 32'hffffffff);
        push_directed(12'hfff, F3_BEQ, OPC_BRANCH, 32'h00000000, 32'hffffffff);
        push_directed(12'hfff, F3_SLT, OPC_LUI, 32'hffffffff, 32'hffffffff);
        push_directed(12'h001, F3_SLTU, OPC_AUIPC, 32'h00000000, 32'h00000000);
        push_directed(12'hfff, F3_AND, OPC_JAL, 32'hffffffff, 32'hffffffff);
        push_directed(12'hfff, F3_AND, OPC_ALL_ONE, 32'hffffffff, 32'hffffffff);
        push_directed(12'h000, F3_ADD, OPC_ALL_ZERO, 32'h00000000, 32'h00000000);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                opc = OPC_RTYPE;
            else if (pick < 40)
                opc = OPC_ITYPE;
            else if (pick < 50)
                opc = OPC_LOAD;
            else if (pick < 60)
                opc = OPC_STORE;
            else if (pick < 72)
                opc = OPC_BRANCH;
            else if (pick < 77)
                opc = OPC_LUI;
            else if (pick < 82)
                opc = OPC_AUIPC;
            else if (pick < 88)
                opc = OPC_JAL;
            else
                opc = 7'($urandom_range(0, 127));
            it.instruction    = $urandom;
            it.instruction[6:0] = opc;
            it.first_operand  = $urandom;
            it.second_operand = $urandom;
            case ($urandom_range(0, 19))
                0: it.first_operand = 32'h00000000;
                1: it.first_operand = 32'hffffffff;
                2: it.first_operand = 32'h80000000;
                3: it.first_operand = 32'h7fffffff;
                default: ;
            endcase
            // equal operands make beq and sub results zero
            if ($urandom_range(0, 99) < 15)
                it.second_operand = it.first_operand;
            if ((opc == OPC_ITYPE || opc == OPC_LOAD) && $urandom_range(0, 9) == 0)
                it.first_operand = -{{20{it.instruction[31]}}, it.instruction[31:20]};
            pending_items.push_back(it);
        end
        total_items = pending_items.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (!(accepted_items == total_items && expected_results.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
